// ===== src/mrf_pkg.sv =====
`timescale 1ns / 1ps

package mrf_pkg;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_MULTI = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [7:0] FN_READ        = 8'h03;
  localparam logic [7:0] FN_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FN_WRITE_MANY  = 8'h10;
  localparam logic [7:0] MULTI_CNT_HI   = 8'h00;
  localparam logic [7:0] MULTI_CNT_LO   = 8'h02;
  localparam logic [7:0] MULTI_BYTE_CNT = 8'h04;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [3:0] LAST_POS_SHORT = 4'd5;
  localparam logic [3:0] LAST_POS_MULTI = 4'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  node_addr;
    logic [15:0] start_reg;
    logic [15:0] value_first;
    logic [15:0] value_second;
  } req_t;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic load;
    logic advance;
  } seq_ctrl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } seq_stat_t;

endpackage

// ===== src/mrf_if.sv =====
`timescale 1ns / 1ps

interface mrf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  node_addr;
  logic [15:0] start_reg;
  logic [15:0] value_first;
  logic [15:0] value_second;

  modport source (
    output valid, kind, node_addr, start_reg, value_first, value_second,
    input  ready
  );
  modport sink (
    input  valid, kind, node_addr, start_reg, value_first, value_second,
    output ready
  );
endinterface

interface mrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (
    output valid, frame_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, last_byte,
    output ready
  );
endinterface

// ===== src/modbus_rtu_request_framer_top.sv =====
// The first frame byte is loaded into the output register from the load state entered after the request transfer.
// Each body byte goes through the load state, then bit-serial CRC steps; CRC bytes come from their own states.
// An 8-byte or 13-byte frame is built per request; no new request is taken mid-frame.
// A new request is taken as soon as the CRC high byte is in the output register.
// Reset (rst_ni low, asynchronous) returns to idle, clears output valid, CRC to 0xFFFF.
`timescale 1ns / 1ps

module modbus_rtu_request_framer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrf_req_if.sink    req_i,
  mrf_byte_if.source frame_o
);
  import mrf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_CRC  = 3'd2;
  localparam logic [2:0] ST_LO   = 3'd3;
  localparam logic [2:0] ST_HI   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       last_body_q, last_body_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_load;
  logic       slot_free;
  logic       accept;

  req_t       req;
  crc_ctrl_t  crc_ctrl;
  seq_ctrl_t  seq_ctrl;
  seq_stat_t  seq_stat;
  logic       crc_busy;
  logic       crc_done;
  logic [15:0] crc_val;

  assign req.kind         = req_i.kind;
  assign req.node_addr    = req_i.node_addr;
  assign req.start_reg    = req_i.start_reg;
  assign req.value_first  = req_i.value_first;
  assign req.value_second = req_i.value_second;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !out_vld_q || frame_o.ready;

  mrf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (seq_ctrl),
    .req_i  (req),
    .stat_o (seq_stat)
  );

  mrf_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .busy_o (crc_busy),
    .done_o (crc_done),
    .crc_o  (crc_val)
  );

  always_comb begin
    state_d          = state_q;
    last_body_d      = last_body_q;
    out_load         = 1'b0;
    out_byte_d       = out_byte_q;
    out_last_d       = out_last_q;
    seq_ctrl.load    = 1'b0;
    seq_ctrl.advance = 1'b0;
    crc_ctrl.init    = 1'b0;
    crc_ctrl.start   = 1'b0;
    crc_ctrl.data    = seq_stat.data;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.kind != KIND_NONE)) begin
          seq_ctrl.load = 1'b1;
          crc_ctrl.init = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          out_load         = 1'b1;
          out_byte_d       = seq_stat.data;
          out_last_d       = 1'b0;
          crc_ctrl.start   = 1'b1;
          seq_ctrl.advance = 1'b1;
          last_body_d      = seq_stat.last;
          state_d          = ST_CRC;
        end
      end
      ST_CRC: begin
        if (crc_done) begin
          state_d = last_body_q ? ST_LO : ST_LOAD;
        end
      end
      ST_LO: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_byte_d = crc_val[7:0];
          out_last_d = 1'b0;
          state_d    = ST_HI;
        end
      end
      ST_HI: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_byte_d = crc_val[15:8];
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (frame_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_body_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_body_q <= last_body_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign frame_o.valid      = out_vld_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.last_byte  = out_last_q;

  a_busy_in_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_busy |-> state_q == ST_CRC)
    else $error("crc running outside crc state");
  a_load_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind != KIND_NONE)) |=> state_q == ST_LOAD)
    else $error("request not started");
  a_drop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind == KIND_NONE)) |=> state_q == ST_IDLE)
    else $error("unused kind started a frame");
  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> state_q == ST_IDLE)
    else $error("frame end without return to idle");

endmodule

// ===== src/mrf_crc.sv =====
`timescale 1ns / 1ps

module mrf_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrf_pkg::crc_ctrl_t ctrl_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [15:0]       crc_o
);
  import mrf_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  sh_q, sh_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        fb;

  // one data bit per cycle, lsb first
  assign fb = crc_q[0] ^ sh_q[0];

  always_comb begin
    crc_d  = crc_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.init) begin
      crc_d  = CRC_INIT;
      busy_d = 1'b0;
    end else if (ctrl_i.start) begin
      sh_d   = ctrl_i.data;
      cnt_d  = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = (crc_q >> 1) ^ (fb ? CRC_POLY : 16'h0000);
      sh_d  = sh_q >> 1;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      cnt_q  <= 3'd0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == 3'd7);
  assign crc_o  = crc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("crc start while busy");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ctrl_i.init && !ctrl_i.start) |=> !busy_q)
    else $error("crc busy after last bit");
  a_eight_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> cnt_q == 3'd0)
    else $error("crc bit count not cleared");

endmodule

// ===== src/mrf_seq.sv =====
`timescale 1ns / 1ps

module mrf_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrf_pkg::seq_ctrl_t ctrl_i,
  input  mrf_pkg::req_t      req_i,
  output mrf_pkg::seq_stat_t stat_o
);
  import mrf_pkg::*;

  req_t       req_q;
  logic [3:0] pos_q, pos_d;
  logic       multi;

  assign multi = (req_q.kind == KIND_MULTI);

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.load) begin
      pos_d = 4'd0;
    end else if (ctrl_i.advance) begin
      pos_d = pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    stat_o.data = 8'h00;
    case (pos_q)
      4'd0: stat_o.data = req_q.node_addr;
      4'd1: begin
        case (req_q.kind)
          KIND_READ:  stat_o.data = FN_READ;
          KIND_WRITE: stat_o.data = FN_WRITE_ONE;
          default:    stat_o.data = FN_WRITE_MANY;
        endcase
      end
      4'd2:  stat_o.data = req_q.start_reg[15:8];
      4'd3:  stat_o.data = req_q.start_reg[7:0];
      4'd4:  stat_o.data = multi ? MULTI_CNT_HI : req_q.value_first[15:8];
      4'd5:  stat_o.data = multi ? MULTI_CNT_LO : req_q.value_first[7:0];
      4'd6:  stat_o.data = MULTI_BYTE_CNT;
      4'd7:  stat_o.data = req_q.value_first[15:8];
      4'd8:  stat_o.data = req_q.value_first[7:0];
      4'd9:  stat_o.data = req_q.value_second[15:8];
      4'd10: stat_o.data = req_q.value_second[7:0];
      default: stat_o.data = 8'h00;
    endcase
    stat_o.last = (pos_q == (multi ? LAST_POS_MULTI : LAST_POS_SHORT));
  end

endmodule
